FILE: rtl/core/crlfd_pkg.sv
// Package for the CR LF line deframer: character codes, line length limits,
// error codes and the result record shared by all of the deframer's modules.
// It depends on nothing else.
package crlfd_pkg;

  // Longest line, counting the CR LF terminator.
  localparam int MAX_LINE = 512;

  // Most content bytes a line may carry.
  localparam int LINE_LIMIT = MAX_LINE - 2;

  // The content count only has to reach LINE_LIMIT.
  localparam int CNT_W = $clog2(LINE_LIMIT + 1);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef logic [CNT_W-1:0] line_cnt_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_BAD_NEWLINE = 2'd1,
    ERR_OVERLONG    = 2'd2
  } err_kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    err_kind_t  error_kind;
  } result_t;

endpackage

FILE: rtl/core/crlfd_line_fsm.sv
// Line state and per-byte decision for the CR LF line deframer.
// Depends on crlfd_pkg.
module crlfd_line_fsm
  import crlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,   // the held byte is consumed this cycle
  input  logic [7:0] in_byte,
  output logic       emit,      // the held byte yields a result
  output result_t    res
);

  line_cnt_t line_count;
  line_cnt_t line_count_next;
  logic      cr_pending;
  logic      cr_pending_next;
  err_kind_t sticky_fault;
  err_kind_t sticky_fault_next;

  always_comb begin
    line_count_next   = line_count;
    cr_pending_next   = cr_pending;
    sticky_fault_next = sticky_fault;
    emit              = 1'b0;
    res.out_byte      = 8'h00;
    res.line_end      = 1'b0;
    res.error_kind    = ERR_NONE;

    if (sticky_fault != ERR_NONE) begin
      // After a fault every byte is dropped.
    end else if (cr_pending) begin
      emit            = 1'b1;
      cr_pending_next = 1'b0;
      if (in_byte == CHAR_LF) begin
        res.line_end    = 1'b1;
        line_count_next = '0;
      end else begin
        res.error_kind    = ERR_BAD_NEWLINE;
        sticky_fault_next = ERR_BAD_NEWLINE;
      end
    end else if (in_byte == CHAR_CR) begin
      cr_pending_next = 1'b1;
    end else if (in_byte == CHAR_LF) begin
      // A lone LF is reported even when the line is already full.
      emit              = 1'b1;
      res.error_kind    = ERR_BAD_NEWLINE;
      sticky_fault_next = ERR_BAD_NEWLINE;
    end else if (line_count >= CNT_W'(LINE_LIMIT)) begin
      emit              = 1'b1;
      res.error_kind    = ERR_OVERLONG;
      sticky_fault_next = ERR_OVERLONG;
    end else begin
      emit            = 1'b1;
      res.out_byte    = in_byte;
      line_count_next = line_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      cr_pending   <= 1'b0;
      sticky_fault <= ERR_NONE;
    end else if (advance) begin
      line_count   <= line_count_next;
      cr_pending   <= cr_pending_next;
      sticky_fault <= sticky_fault_next;
    end
  end

endmodule

FILE: rtl/core/crlfd_out_reg.sv
// Result register of the CR LF line deframer, holding one result until the
// downstream side takes it. Depends on crlfd_pkg.
module crlfd_out_reg
  import crlfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  input  logic    take,      // downstream ready
  output logic    valid,
  output result_t dout,
  output logic    free       // a new result may be loaded this cycle
);

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

FILE: rtl/core/crlf_line_deframer.sv
// Top level of the CR LF line deframer: input register, line decision logic
// and result register. Depends on crlfd_pkg, crlfd_line_fsm and crlfd_out_reg.

// The deframer takes one received byte per transaction and splits the stream
// into lines terminated by CR LF. Every content byte comes out at once as a
// result of its own; a CR is held back and produces nothing, and the LF that
// follows it produces a single result with tlast high and zero data. A lone
// LF, or a CR followed by anything other than LF, gives one result with
// tuser set to the bad-newline code; a content byte arriving when the line
// already carries MAX_LINE-2 bytes gives one result with the overlong code.
// Either error is sticky: all later bytes are accepted and dropped until
// reset, so the consumer should discard the partial line it has collected
// when an error is reported. The block sustains one byte per clock while
// the receiver keeps ready high. A byte is held in the input register, is
// decided by single-level logic and is then registered in the result
// register, which presents it until it is taken. Input ready falls only
// while both the input and the result register are full and the result
// is not being taken.
module crlf_line_deframer
  import crlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // line_end
  output logic [1:0] m_axis_tuser    // [1:0] error_kind
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       emit;
  logic       out_free;
  result_t    res;
  result_t    out_res;

  // The held byte moves on whenever the result register can take a result,
  // whether or not this byte produces one.
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  crlfd_line_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .emit    (emit),
    .res     (res)
  );

  crlfd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance && emit),
    .din   (res),
    .take  (m_axis_tready),
    .valid (m_axis_tvalid),
    .dout  (out_res),
    .free  (out_free)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.line_end;
  assign m_axis_tuser = out_res.error_kind;

`ifndef SYNTH
  // A line end never carries an error code.
  a_end_no_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tlast && (m_axis_tuser != ERR_NONE)))
    else $error("line end reported together with an error");

  // Line ends and errors carry zero data.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tlast || (m_axis_tuser != ERR_NONE)))
      |-> (m_axis_tdata == 8'h00))
    else $error("nonzero data on a line end or error result");

  // Once an error has been delivered, nothing more comes out.
  a_silent_after_err: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && (m_axis_tuser != ERR_NONE))
      |=> !m_axis_tvalid)
    else $error("result delivered after a sticky error");

  // An empty result register always lets a byte in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result register is empty");
`endif

endmodule

FILE: dv/crlfd_line_checker.sv
// Checker for the CR LF line deframer testbench: watches both streams,
// predicts each line result and compares it field by field.
// Depends on crlfd_pkg for the character codes, limits and result record.
`timescale 1ns / 1ps

module crlfd_line_checker
  import crlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tlast,
  input  logic [1:0] m_axis_tuser,
  output int         mismatch_count,
  output int         results_pending
);

  line_cnt_t line_len;
  logic      cr_seen;
  err_kind_t stuck_err;

  result_t   line_results_q[$];

  // Decides one received byte against the current line state.
  function automatic void frame_byte(input logic [7:0] b, output bit emits,
                                     output result_t r);
    emits        = 1'b0;
    r.out_byte   = 8'h00;
    r.line_end   = 1'b0;
    r.error_kind = ERR_NONE;
    if (stuck_err != ERR_NONE) begin
      // Dropped silently until reset.
    end else if (cr_seen) begin
      emits   = 1'b1;
      cr_seen = 1'b0;
      if (b == CHAR_LF) begin
        r.line_end = 1'b1;
        line_len   = '0;
      end else begin
        r.error_kind = ERR_BAD_NEWLINE;
        stuck_err    = ERR_BAD_NEWLINE;
      end
    end else if (b == CHAR_CR) begin
      cr_seen = 1'b1;
    end else if (b == CHAR_LF) begin
      emits        = 1'b1;
      r.error_kind = ERR_BAD_NEWLINE;
      stuck_err    = ERR_BAD_NEWLINE;
    end else if (line_len >= line_cnt_t'(LINE_LIMIT)) begin
      emits        = 1'b1;
      r.error_kind = ERR_OVERLONG;
      stuck_err    = ERR_OVERLONG;
    end else begin
      emits      = 1'b1;
      line_len   = line_len + 1'b1;
      r.out_byte = b;
    end
  endfunction

  always @(posedge clk) begin
    bit      emits;
    result_t want;
    if (rst) begin
      line_len  = '0;
      cr_seen   = 1'b0;
      stuck_err = ERR_NONE;
      line_results_q.delete();
    end else begin
      // Check the output first so that a result can never match a byte
      // accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_results_q.size() == 0) begin
          $display("%0t: unexpected result, data %02h last %0b user %0d", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = line_results_q.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h", $time,
                     want.out_byte, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.line_end) begin
            $display("%0t: line_end expected %0b, got %0b", $time,
                     want.line_end, m_axis_tlast);
            mismatch_count++;
          end
          if (m_axis_tuser !== want.error_kind) begin
            $display("%0t: error_kind expected %0d, got %0d", $time,
                     want.error_kind, m_axis_tuser);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        frame_byte(s_axis_tdata, emits, want);
        if (emits) line_results_q.push_back(want);
      end
    end
    results_pending <= line_results_q.size();
  end

endmodule

FILE: dv/tb_crlf_line_deframer.sv
// Testbench top for the CR LF line deframer: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on crlfd_pkg, the
// deframer RTL and crlfd_line_checker.
`timescale 1ns / 1ps

module tb_crlf_line_deframer;
  import crlfd_pkg::*;

  // A quiet stretch longer than this means the block has hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver stall that fills the pipeline.
  localparam int HOLD_CYCLES    = 300;
  // Fewest bytes sent in each idling phase of the random part; a phase ends on a whole line.
  localparam int PHASE_BYTES    = 32;

  // How the run is brought into the sticky error state at the very end.
  // Only one error can happen per reset, so the seed picks which one.
  typedef enum int {
    TAIL_LONE_LF,
    TAIL_CR_OTHER,
    TAIL_CR_CR,
    TAIL_OVERLONG,
    TAIL_LF_ON_FULL
  } tail_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  int mismatch_count;
  int results_pending;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_sent  = 0;
  int quiet_cycles = 0;

  // The stimulus flips hold_toggle to ask for a long receiver stall; the
  // ready process notices the change and counts the stall out itself.
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  always #2 clk = ~clk;

  crlf_line_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  crlfd_line_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Receiver side: random ready at the current idle rate, except during a
  // requested stall, when ready is held low until the HOLD_CYCLES count runs out.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any transaction on either stream restarts the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_crlf_line_deframer: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte, possibly after a few idle cycles, and returns at the
  // edge where the transaction completes. Valid stays high between bytes unless the sender idles.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // A random byte that is neither CR nor LF, so it counts as line content.
  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CHAR_CR || b == CHAR_LF) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly short lines, some medium ones and now and then a longer one.
  // Full-length lines are sent by the directed part.
  function automatic int pick_line_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(12);
    else if (r < 95) return $urandom_range(60, 13);
    else return $urandom_range(100, 61);
  endfunction

  task automatic send_content(input int len);
    for (int i = 0; i < len; i++) send_byte(content_byte());
  endtask

  task automatic send_line(input int len);
    send_content(len);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // Stops offering bytes until every predicted result has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct);
    int target;
    target      = bytes_sent + PHASE_BYTES;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (bytes_sent < target) send_line(pick_line_len());
  endtask

  initial begin
    logic [7:0] edge_bytes[10];
    tail_kind_t tail;

    edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                   8'h09, 8'h0B, 8'h0C, 8'h0E};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: extreme byte values and the neighbors of CR and LF,
    // then two empty lines back to back and a one-byte line.
    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_line(0);
    send_line(0);
    send_line(1);

    // Well-formed lines with random content under three idling patterns.
    random_phase(6, 83);
    random_phase(83, 6);
    random_phase(0, 0);

    // A line with exactly the most content it may carry is still legal.
    send_line(LINE_LIMIT);

    // Stall the receiver long enough that the block fills and drops its
    // input ready while bytes keep being offered, then let it all drain.
    hold_toggle <= ~hold_toggle;
    send_line(30);
    wait_drained();
    send_line(pick_line_len());

    // End in one of the sticky errors, followed by noise bytes that must
    // all be dropped without a result.
    tail = tail_kind_t'($urandom_range(TAIL_LF_ON_FULL, TAIL_LONE_LF));
    case (tail)
      TAIL_LONE_LF: begin
        send_content($urandom_range(8));
        send_byte(CHAR_LF);
      end
      TAIL_CR_OTHER: begin
        send_content($urandom_range(8));
        send_byte(CHAR_CR);
        send_byte(content_byte());
      end
      TAIL_CR_CR: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
      end
      TAIL_OVERLONG: begin
        send_content(LINE_LIMIT);
        send_byte(content_byte());
      end
      TAIL_LF_ON_FULL: begin
        // The newline check wins over the length check on a full line.
        send_content(LINE_LIMIT);
        send_byte(CHAR_LF);
      end
      default: begin
        send_byte(CHAR_LF);
      end
    endcase
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    repeat (20) send_byte(8'($urandom_range(255)));

    wait_drained();
    // Leave room for any stray late result.
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_crlf_line_deframer: clean");
    end else begin
      $display("tb_crlf_line_deframer: errors");
    end
    $finish;
  end

endmodule

FILE: crlf_line_deframer.f
rtl/core/crlfd_pkg.sv
rtl/core/crlfd_line_fsm.sv
rtl/core/crlfd_out_reg.sv
rtl/core/crlf_line_deframer.sv
dv/crlfd_line_checker.sv
dv/tb_crlf_line_deframer.sv
